>>> design/osl_pkg.sv
// ----------------------------------------------------------------------------
// Oversampled slew limiter: shared definitions
// Fixed constants, micro-operation encoding and the step program that the
// core sequencer runs for every sample word.
// ----------------------------------------------------------------------------
package osl_pkg;

    // Fraction bits of the internal format and of the coefficients.
    localparam int IFRAC = 32;
    localparam int KFRAC = 18;
    localparam int K_W   = 19;

    // Coefficients with 18 fraction bits.
    localparam logic [K_W-1:0] K_TWEAK = 19'd10858;   // 0.0414214
    localparam logic [K_W-1:0] K_DECAY = 19'd240115;  // 0.9159656
    localparam logic [K_W-1:0] K_GAIN  = 19'd357144;  // 1 / 0.734

    typedef enum logic [3:0] {
        OP_SUB,
        OP_ADD,
        OP_ADDSAT,
        OP_SUBSAT,
        OP_HALFSAT,
        OP_CLAMP,
        OP_HALF,
        OP_MUL,
        OP_END
    } op_t;

    typedef enum logic [3:0] {
        SRC_X,
        SRC_P0,
        SRC_P1,
        SRC_P2,
        SRC_LL,
        SRC_HDRY,
        SRC_ACCA,
        SRC_ACCB,
        SRC_HD,
        SRC_DF,
        SRC_PHD,
        SRC_Y,
        SRC_T
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_T,
        DST_HDRY,
        DST_LL,
        DST_ACCA,
        DST_ACCB,
        DST_HD,
        DST_DF,
        DST_PHD,
        DST_Y
    } dst_t;

    typedef enum logic [1:0] {
        KSEL_TWEAK,
        KSEL_DECAY,
        KSEL_GAIN
    } ksel_t;

    typedef struct packed {
        op_t   op;
        src_t  a;
        src_t  b;
        ksel_t k;
        dst_t  dst;
    } uop_t;

    // Handshake status from the core to the stream wrapper.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_stat_t;

    localparam int NSTEPS = 26;
    localparam int STEP_W = $clog2(NSTEPS);

    function automatic logic [K_W-1:0] kval(ksel_t k);
        logic [K_W-1:0] r;
        unique case (k)
            KSEL_TWEAK: r = K_TWEAK;
            KSEL_DECAY: r = K_DECAY;
            KSEL_GAIN:  r = K_GAIN;
            default:    r = K_DECAY;
        endcase
        return r;
    endfunction

    function automatic uop_t mk_uop(op_t o, src_t a, src_t b, ksel_t k, dst_t d);
        uop_t r;
        r.op  = o;
        r.a   = a;
        r.b   = b;
        r.k   = k;
        r.dst = d;
        return r;
    endfunction

    // Step program for one sample: first the interpolated halfway sample
    // is limited, then the input sample itself, then the output is formed.
    function automatic uop_t ucode(logic [STEP_W-1:0] step);
        uop_t r;
        unique case (int'(step))
            0:  r = mk_uop(OP_SUB,     SRC_P2,   SRC_P1,   KSEL_DECAY, DST_T);
            1:  r = mk_uop(OP_MUL,     SRC_T,    SRC_X,    KSEL_TWEAK, DST_T);
            2:  r = mk_uop(OP_ADD,     SRC_T,    SRC_X,    KSEL_DECAY, DST_T);
            3:  r = mk_uop(OP_HALFSAT, SRC_T,    SRC_P0,   KSEL_DECAY, DST_HDRY);
            4:  r = mk_uop(OP_SUB,     SRC_HDRY, SRC_LL,   KSEL_DECAY, DST_T);
            5:  r = mk_uop(OP_CLAMP,   SRC_HDRY, SRC_X,    KSEL_DECAY, DST_LL);
            6:  r = mk_uop(OP_SUB,     SRC_LL,   SRC_HDRY, KSEL_DECAY, DST_T);
            7:  r = mk_uop(OP_MUL,     SRC_ACCB, SRC_X,    KSEL_DECAY, DST_ACCB);
            8:  r = mk_uop(OP_MUL,     SRC_ACCA, SRC_X,    KSEL_DECAY, DST_ACCA);
            9:  r = mk_uop(OP_ADDSAT,  SRC_ACCB, SRC_T,    KSEL_DECAY, DST_ACCB);
            10: r = mk_uop(OP_SUBSAT,  SRC_ACCA, SRC_T,    KSEL_DECAY, DST_ACCA);
            11: r = mk_uop(OP_MUL,     SRC_ACCB, SRC_X,    KSEL_DECAY, DST_HD);
            12: r = mk_uop(OP_SUB,     SRC_X,    SRC_LL,   KSEL_DECAY, DST_T);
            13: r = mk_uop(OP_CLAMP,   SRC_X,    SRC_X,    KSEL_DECAY, DST_LL);
            14: r = mk_uop(OP_SUB,     SRC_LL,   SRC_X,    KSEL_DECAY, DST_T);
            15: r = mk_uop(OP_MUL,     SRC_ACCA, SRC_X,    KSEL_DECAY, DST_ACCA);
            16: r = mk_uop(OP_MUL,     SRC_ACCB, SRC_X,    KSEL_DECAY, DST_ACCB);
            17: r = mk_uop(OP_ADDSAT,  SRC_ACCA, SRC_T,    KSEL_DECAY, DST_ACCA);
            18: r = mk_uop(OP_SUBSAT,  SRC_ACCB, SRC_T,    KSEL_DECAY, DST_ACCB);
            19: r = mk_uop(OP_MUL,     SRC_ACCA, SRC_X,    KSEL_DECAY, DST_DF);
            20: r = mk_uop(OP_ADD,     SRC_DF,   SRC_HD,   KSEL_DECAY, DST_T);
            21: r = mk_uop(OP_ADDSAT,  SRC_T,    SRC_PHD,  KSEL_DECAY, DST_Y);
            22: r = mk_uop(OP_MUL,     SRC_Y,    SRC_X,    KSEL_GAIN,  DST_Y);
            23: r = mk_uop(OP_ADDSAT,  SRC_X,    SRC_Y,    KSEL_DECAY, DST_Y);
            24: r = mk_uop(OP_HALF,    SRC_DF,   SRC_X,    KSEL_DECAY, DST_PHD);
            default: r = mk_uop(OP_END, SRC_Y,   SRC_X,    KSEL_DECAY, DST_NONE);
        endcase
        return r;
    endfunction

endpackage

>>> design/osl_mulk.sv
// ----------------------------------------------------------------------------
// Oversampled slew limiter: coefficient multiplier
// Computes floor((v * k + 2^17) / 2^18) with one narrow multiplier used for
// the low and then the high half of v, followed by a combining add.
// ----------------------------------------------------------------------------
module osl_mulk import osl_pkg::*; #(
    parameter int WW = 43
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [WW-1:0] v,
    input  logic [K_W-1:0]       k,
    output logic                 done,
    output logic signed [WW-1:0] result
);

    localparam int LW = (WW + 1) / 2;
    localparam int HW = WW - LW;
    localparam int PW = LW + K_W + 2;
    localparam int SW = WW + K_W + 2;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_LO   = 4'b0010,
        M_HI   = 4'b0100,
        M_SUM  = 4'b1000
    } mstate_t;

    mstate_t state_reg, state_next;
    logic signed [WW-1:0] v_reg;
    logic [K_W-1:0]       k_reg;
    logic signed [PW-1:0] plo_reg;
    logic signed [PW-1:0] phi_reg;
    logic signed [WW-1:0] result_reg;
    logic                 done_reg;

    logic signed [LW:0]   mul_a;
    logic signed [K_W:0]  mul_b;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] sum;

    // The low half goes in as an unsigned value, the high half sign-extended.
    always_comb
    begin
        if (state_reg == M_HI)
        begin
            mul_a = $signed({{(LW + 1 - HW){v_reg[WW-1]}}, v_reg[WW-1:LW]});
        end
        else
        begin
            mul_a = $signed({1'b0, v_reg[LW-1:0]});
        end
        mul_b = $signed({1'b0, k_reg});
        prod  = mul_a * mul_b;
        sum   = (SW'(phi_reg) <<< LW) + SW'(plo_reg) + (SW'(1) <<< (KFRAC - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_LO;
                end
            end
            M_LO:    state_next = M_HI;
            M_HI:    state_next = M_SUM;
            M_SUM:   state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == M_SUM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            v_reg <= v;
            k_reg <= k;
        end
        if (state_reg == M_LO)
        begin
            plo_reg <= prod;
        end
        if (state_reg == M_HI)
        begin
            phi_reg <= prod;
        end
        if (state_reg == M_SUM)
        begin
            result_reg <= sum[KFRAC +: WW];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == M_IDLE)
        else $error("multiplier started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held for more than one cycle");

endmodule

>>> design/osl_core.sv
// ----------------------------------------------------------------------------
// Oversampled slew limiter: sequencer and datapath
// Steps through the sample program with one adder/compare unit and the
// shared coefficient multiplier, and holds the filter state.
// ----------------------------------------------------------------------------
module osl_core import osl_pkg::*; #(
    parameter int SB = 24,
    parameter int IB = 40,
    parameter int WW = 43
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [SB-1:0] sample,
    input  logic [SB-2:0]        slew,
    input  logic                 res_ready,
    output core_stat_t           stat,
    output logic signed [SB-1:0] res_data
);

    localparam int SHIFT_IN = IFRAC - (SB - 1);
    localparam logic signed [WW-1:0] IMAX = {{(WW - IB + 1){1'b0}}, {(IB - 1){1'b1}}};
    localparam logic signed [WW-1:0] IMIN = ~IMAX;
    localparam logic signed [WW-1:0] SMAX = {{(WW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [WW-1:0] SMIN = ~SMAX;
    localparam logic signed [WW-1:0] RND  = {{(WW - 1){1'b0}}, 1'b1} << (SHIFT_IN - 1);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_RUN  = 4'b0010,
        C_MUL  = 4'b0100,
        C_DONE = 4'b1000
    } cstate_t;

    cstate_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic signed [SB-1:0] s_reg;
    logic signed [SB-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [WW-1:0] ll_reg, acca_reg, accb_reg, phd_reg;
    logic signed [WW-1:0] t_reg, hdry_reg, hd_reg, df_reg, y_reg, nthr_reg;
    logic signed [SB-1:0] res_reg;

    uop_t                 uop;
    logic signed [WW-1:0] thr;
    logic signed [WW-1:0] opa, opb;
    logic signed [WW-1:0] sum_ab, diff_ab, clamp_sum, alu_res;
    logic signed [WW-1:0] rnd, shq;
    logic signed [SB-1:0] out_val;
    logic                 cmp_hi, cmp_lo;
    logic                 wr_en, end_go, load, mul_start, mul_done;
    logic signed [WW-1:0] mul_res, wr_val;

    function automatic logic signed [WW-1:0] to_int(logic signed [SB-1:0] s);
        return WW'(s) <<< SHIFT_IN;
    endfunction

    function automatic logic signed [WW-1:0] sat(logic signed [WW-1:0] v);
        logic signed [WW-1:0] r;
        if (v > IMAX)
        begin
            r = IMAX;
        end
        else if (v < IMIN)
        begin
            r = IMIN;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [WW-1:0] operand(src_t s);
        logic signed [WW-1:0] r;
        unique case (s)
            SRC_X:    r = to_int(s_reg);
            SRC_P0:   r = to_int(p0_reg);
            SRC_P1:   r = to_int(p1_reg);
            SRC_P2:   r = to_int(p2_reg);
            SRC_LL:   r = ll_reg;
            SRC_HDRY: r = hdry_reg;
            SRC_ACCA: r = acca_reg;
            SRC_ACCB: r = accb_reg;
            SRC_HD:   r = hd_reg;
            SRC_DF:   r = df_reg;
            SRC_PHD:  r = phd_reg;
            SRC_Y:    r = y_reg;
            SRC_T:    r = t_reg;
            default:  r = t_reg;
        endcase
        return r;
    endfunction

    assign thr = $signed(WW'({1'b0, slew})) <<< SHIFT_IN;

    always_comb
    begin
        uop     = ucode(step_reg);
        opa     = operand(uop.a);
        opb     = operand(uop.b);
        sum_ab  = opa + opb;
        diff_ab = opa - opb;
        // t_reg holds the distance to the last limited value at a clamp step.
        cmp_hi    = t_reg > thr;
        cmp_lo    = t_reg < nthr_reg;
        clamp_sum = ll_reg + (cmp_hi ? thr : nthr_reg);
        unique case (uop.op)
            OP_SUB:     alu_res = diff_ab;
            OP_ADD:     alu_res = sum_ab;
            OP_ADDSAT:  alu_res = sat(sum_ab);
            OP_SUBSAT:  alu_res = sat(diff_ab);
            OP_HALFSAT: alu_res = sat(sum_ab >>> 1);
            OP_CLAMP:   alu_res = (cmp_hi || cmp_lo) ? sat(clamp_sum) : opa;
            OP_HALF:    alu_res = opa >>> 1;
            default:    alu_res = opa;
        endcase
    end

    // Round half up to sample precision, then clip to full scale.
    always_comb
    begin
        rnd = y_reg + RND;
        shq = rnd >>> SHIFT_IN;
        if (shq > SMAX)
        begin
            out_val = SMAX[SB-1:0];
        end
        else if (shq < SMIN)
        begin
            out_val = SMIN[SB-1:0];
        end
        else
        begin
            out_val = shq[SB-1:0];
        end
    end

    assign load      = (state_reg == C_IDLE) && start;
    assign mul_start = (state_reg == C_RUN) && (uop.op == OP_MUL);
    assign end_go    = (state_reg == C_RUN) && (uop.op == OP_END);
    assign wr_en     = ((state_reg == C_RUN) && (uop.op != OP_MUL) && (uop.op != OP_END))
                     || ((state_reg == C_MUL) && mul_done);
    assign wr_val    = (state_reg == C_MUL) ? mul_res : alu_res;

    osl_mulk #(
        .WW(WW)
    ) u_mulk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .v     (opa),
        .k     (kval(uop.k)),
        .done  (mul_done),
        .result(mul_res)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_RUN;
                    step_next  = '0;
                end
            end
            C_RUN:
            begin
                if (uop.op == OP_MUL)
                begin
                    state_next = C_MUL;
                end
                else if (uop.op == OP_END)
                begin
                    state_next = C_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            C_MUL:
            begin
                if (mul_done)
                begin
                    state_next = C_RUN;
                    step_next  = step_reg + 1'b1;
                end
            end
            C_DONE:
            begin
                if (res_ready)
                begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            p0_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            ll_reg    <= '0;
            acca_reg  <= '0;
            accb_reg  <= '0;
            phd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (wr_en && uop.dst == DST_LL)
            begin
                ll_reg <= wr_val;
            end
            if (wr_en && uop.dst == DST_ACCA)
            begin
                acca_reg <= wr_val;
            end
            if (wr_en && uop.dst == DST_ACCB)
            begin
                accb_reg <= wr_val;
            end
            if (wr_en && uop.dst == DST_PHD)
            begin
                phd_reg <= wr_val;
            end
            if (end_go)
            begin
                p2_reg <= p1_reg;
                p1_reg <= p0_reg;
                p0_reg <= s_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s_reg    <= sample;
            nthr_reg <= -thr;
        end
        if (wr_en && uop.dst == DST_T)
        begin
            t_reg <= wr_val;
        end
        if (wr_en && uop.dst == DST_HDRY)
        begin
            hdry_reg <= wr_val;
        end
        if (wr_en && uop.dst == DST_HD)
        begin
            hd_reg <= wr_val;
        end
        if (wr_en && uop.dst == DST_DF)
        begin
            df_reg <= wr_val;
        end
        if (wr_en && uop.dst == DST_Y)
        begin
            y_reg <= wr_val;
        end
        if (end_go)
        begin
            res_reg <= out_val;
        end
    end

    assign stat.idle      = (state_reg == C_IDLE);
    assign stat.res_valid = (state_reg == C_DONE);
    assign res_data       = res_reg;

    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == C_MUL)
        else $error("multiplier result arrived while the sequencer was not waiting");

endmodule

>>> design/oversampled_slew_limiter.sv
// The core takes a new input word only after it has handed the previous one
// to the output register. Each word runs through 8 uses of the shared
// coefficient multiplier, 17 add/compare steps and the closing step.
// A finished word waits in the output register while the next one is taken.
// Reset (rst_n, asynchronous, active low) clears the filter state and history
// and sets slew_limit to half of full scale.
// ----------------------------------------------------------------------------
// Oversampled slew limiter
// Stream wrapper: input handshake, slew_limit register and output register
// around the sequenced core.
// ----------------------------------------------------------------------------
module oversampled_slew_limiter import osl_pkg::*; #(
    parameter int SAMPLE_BITS   = 24,
    parameter int INTERNAL_BITS = 40,
    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDW-1:0]         s_axis_tdata,   // sample_in, upper bits zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDW-1:0]         m_axis_tdata,   // sample_out, upper bits zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SAMPLE_BITS-2:0] cfg_data        // slew_limit
);

    localparam int WW = ((INTERNAL_BITS > 34) ? INTERNAL_BITS : 34) + 3;
    localparam logic [SAMPLE_BITS-2:0] SLEW_RESET =
        {1'b1, {(SAMPLE_BITS - 2){1'b0}}};

    logic [SAMPLE_BITS-2:0]        slew_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    core_stat_t                    core_stat;
    logic                          res_ready;
    logic signed [SAMPLE_BITS-1:0] res_data;
    logic                          in_go;

    assign s_axis_tready = core_stat.idle;
    assign in_go         = s_axis_tvalid && s_axis_tready;
    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    osl_core #(
        .SB(SAMPLE_BITS),
        .IB(INTERNAL_BITS),
        .WW(WW)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_go),
        .sample   ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .slew     (slew_reg),
        .res_ready(res_ready),
        .stat     (core_stat),
        .res_data (res_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_reg      <= SLEW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                slew_reg <= cfg_data;
            end
            if (core_stat.res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_stat.res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDW'($unsigned(out_data_reg));

    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.res_valid && res_ready |=> out_valid_reg && core_stat.idle)
        else $error("finished word did not reach the output register");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_go |=> !core_stat.idle && !core_stat.res_valid)
        else $error("core did not start on an accepted word");

endmodule

>>> verif/osl_checker.sv
// ----------------------------------------------------------------------------
// Oversampled slew limiter: stream checker
// Watches the limit register channel and both sample streams, predicts each
// output word from its own copy of the filter state and compares it with the
// word that the block actually delivers.
// ----------------------------------------------------------------------------
module osl_checker import osl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [23:0] s_data,     // sample_in
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [23:0] m_data,     // sample_out
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [22:0] cfg_data,   // slew_limit
    output int          fail_count,
    output int          words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint INT_MAX   = (64'sd1 <<< 39) - 1;
    localparam longint INT_MIN   = -INT_MAX - 1;
    localparam longint SMP_MAX   = (64'sd1 <<< 23) - 1;
    localparam longint SMP_MIN   = -SMP_MAX - 1;
    localparam int     IN_SHIFT  = IFRAC - 23;
    localparam longint RESET_LIM = 4194304;

    longint      slew_cur;
    longint      hist [0:2];
    longint      lim_prev;
    longint      acc_a;
    longint      acc_b;
    longint      half_prev;
    logic [23:0] expected_q [$];
    logic [23:0] want;

    function automatic longint sat_int(longint v);
        if (v > INT_MAX)
            return INT_MAX;
        if (v < INT_MIN)
            return INT_MIN;
        return v;
    endfunction

    // Coefficient product, rounded half up at the 18-bit fraction.
    function automatic longint coef_mul(longint v, logic [K_W-1:0] k);
        longint hi;
        longint lo;
        longint kk;
        kk = longint'(k);
        hi = v >>> KFRAC;
        lo = v & ((64'sd1 <<< KFRAC) - 1);
        return hi * kk + ((lo * kk + (64'sd1 <<< (KFRAC - 1))) >>> KFRAC);
    endfunction

    function automatic longint slew_clamp(longint v, longint thr);
        longint d;
        d = v - lim_prev;
        if (d > thr)
            v = sat_int(lim_prev + thr);
        if (-d > thr)
            v = sat_int(lim_prev - thr);
        return v;
    endfunction

    // Advances the filter by one input word and returns the limited sample.
    function automatic logic [23:0] limited_sample(logic [23:0] raw);
        longint s;
        longint x;
        longint thr;
        longint h;
        longint h_dry;
        longint c;
        longint hd;
        longint df;
        longint y;
        s   = longint'($signed(raw));
        x   = s <<< IN_SHIFT;
        thr = slew_cur <<< IN_SHIFT;

        h = x + (hist[0] <<< IN_SHIFT)
              + coef_mul((hist[2] - hist[1]) <<< IN_SHIFT, K_TWEAK);
        h = sat_int(h >>> 1);
        h_dry = h;
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = s;

        // Halfway sample first, then the input sample itself.
        h = slew_clamp(h, thr);
        lim_prev = h;
        c = h - h_dry;
        acc_b = coef_mul(acc_b, K_DECAY);
        acc_a = coef_mul(acc_a, K_DECAY);
        acc_b = sat_int(acc_b + c);
        acc_a = sat_int(acc_a - c);
        hd = coef_mul(acc_b, K_DECAY);

        y = slew_clamp(x, thr);
        lim_prev = y;
        c = y - x;
        acc_a = coef_mul(acc_a, K_DECAY);
        acc_b = coef_mul(acc_b, K_DECAY);
        acc_a = sat_int(acc_a + c);
        acc_b = sat_int(acc_b - c);
        df = coef_mul(acc_a, K_DECAY);

        y = sat_int(df + hd + half_prev);
        y = sat_int(x + coef_mul(y, K_GAIN));
        half_prev = df >>> 1;

        y = (y + (64'sd1 <<< (IN_SHIFT - 1))) >>> IN_SHIFT;
        if (y > SMP_MAX)
            y = SMP_MAX;
        if (y < SMP_MIN)
            y = SMP_MIN;
        return y[23:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_cur   = RESET_LIM;
            hist[0]    = 0;
            hist[1]    = 0;
            hist[2]    = 0;
            lim_prev   = 0;
            acc_a      = 0;
            acc_b      = 0;
            half_prev  = 0;
            expected_q.delete();
            fail_count = 0;
            words_pending = 0;
        end
        else
        begin
            // The output side is checked first: a word leaving in the same
            // cycle always belongs to an older input.
            if (m_valid && m_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected output word %0d", $time, $signed(m_data));
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_data !== want)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_data));
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                slew_cur = longint'(cfg_data);
            if (s_valid && s_ready)
                expected_q.push_back(limited_sample(s_data));
            words_pending = expected_q.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Oversampled slew limiter: testbench top
// Drives sample words and slew_limit writes into the block with random gaps
// and output back-pressure, and reports the verdict of the stream checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [22:0] LIM_MAX = 23'h7FFFFF;
    localparam logic [23:0] S_MAX   = 24'h7FFFFF;
    localparam logic [23:0] S_MIN   = 24'h800000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // sample_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // sample_out
    logic        cfg_valid;
    logic        cfg_ready;
    logic [22:0] cfg_data;        // slew_limit
    int          fail_count;
    int          words_pending;
    bit          quiet;
    bit          hold_req;
    int          hold_left;

    oversampled_slew_limiter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    osl_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_valid       (s_axis_tvalid),
        .s_ready       (s_axis_tready),
        .s_data        (s_axis_tdata),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .m_data        (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off on request so the
    // block fills up and stops taking input.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 400;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= (!quiet && $urandom_range(0, 99) < 36) ? 1'b0 : 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(logic [23:0] d);
        while (!quiet && $urandom_range(0, 99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Waits until every output word has come back, then writes the limit.
    task automatic write_limit(logic [22:0] v);
        s_axis_tvalid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [23:0] val;
        logic [22:0] lim;
        int          walk;
        int          amp;
        int          kind;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        walk          = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset limit of half scale: silence, extremes and full-scale jumps
        // that the limiter has to clamp in both directions.
        send_word(24'h000000);
        send_word(24'h000000);
        send_word(S_MAX);
        send_word(S_MAX);
        send_word(S_MIN);
        send_word(S_MAX);
        send_word(S_MIN);
        send_word(24'h000001);
        send_word(24'hFFFFFF);
        send_word(24'h555555);
        send_word(24'hAAAAAA);

        // A zero limit holds the last limited value.
        write_limit('0);
        send_word(S_MAX);
        send_word(S_MIN);
        send_word(24'h003039);

        // The widest limit, with full-scale jumps between the extremes.
        write_limit(LIM_MAX);
        send_word(S_MAX);
        send_word(S_MIN);
        send_word(S_MAX);
        send_word(S_MIN);
        send_word(24'h000000);

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       lim = 23'd1;
                1:       lim = 23'($urandom_range(0, 32'h7FFFFF));
                2:       lim = 23'($urandom_range(1, 4096));
                3:       lim = '0;
                default: lim = LIM_MAX;
            endcase
            write_limit(lim);
            for (int i = 0; i < 130; i++)
            begin
                quiet = (phase == 2 && i < 100);
                if (phase == 1 && i == 50)
                    hold_req = 1'b1;
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1:
                        val = 24'($urandom());
                    2:
                        val = $urandom_range(0, 1) ? S_MAX : S_MIN;
                    3:
                        val = 24'(int'($urandom_range(0, 64)) - 32);
                    default:
                    begin
                        // Random walk: a band-limited signal with random step.
                        amp = 1 << $urandom_range(4, 21);
                        walk += int'($urandom_range(0, 2 * amp)) - amp;
                        if (walk > 8388607)
                            walk = 8388607;
                        if (walk < -8388608)
                            walk = -8388608;
                        val = 24'(walk);
                    end
                endcase
                send_word(val);
            end
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (words_pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
design/osl_pkg.sv
design/osl_mulk.sv
design/osl_core.sv
design/oversampled_slew_limiter.sv
verif/osl_checker.sv
verif/tb_top.sv
